/* sv/iorm_pkg.sv */
// ----------------------------------------------------------------------------
// iorm_pkg
// Shared widths, defaults, register indexes, item kinds and orientation codes
// for the orientation remap block and its channel interfaces.
// ----------------------------------------------------------------------------
package iorm_pkg;

   // Fixed port widths.
   localparam int SAMPLE_PORT_BITS = 16;
   localparam int COORD_PORT_BITS  = 8;
   localparam int CFG_DIM_BITS     = 9;
   localparam int CFG_CODE_BITS    = 4;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 9;

   // Defaults for the top-level parameters.
   localparam int MAX_DIM_DEFAULT     = 256;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIENTATION  = 2'd2;

   // Item kinds.
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   // EXIF orientation codes.
   localparam logic [CFG_CODE_BITS-1:0] ORIENT_TOP_LEFT     = 4'd1;
   localparam logic [CFG_CODE_BITS-1:0] ORIENT_TOP_RIGHT    = 4'd2;
   localparam logic [CFG_CODE_BITS-1:0] ORIENT_BOTTOM_RIGHT = 4'd3;
   localparam logic [CFG_CODE_BITS-1:0] ORIENT_BOTTOM_LEFT  = 4'd4;
   localparam logic [CFG_CODE_BITS-1:0] ORIENT_LEFT_TOP     = 4'd5;
   localparam logic [CFG_CODE_BITS-1:0] ORIENT_RIGHT_TOP    = 4'd6;
   localparam logic [CFG_CODE_BITS-1:0] ORIENT_RIGHT_BOTTOM = 4'd7;
   localparam logic [CFG_CODE_BITS-1:0] ORIENT_LEFT_BOTTOM  = 4'd8;

endpackage

/* sv/iorm_req_if.sv */
// ----------------------------------------------------------------------------
// iorm_req_if
// Input channel: one word writes a raster pixel or fetches an oriented pixel.
// ----------------------------------------------------------------------------
interface iorm_req_if;
   import iorm_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [SAMPLE_PORT_BITS-1:0] red_in;
   logic [SAMPLE_PORT_BITS-1:0] green_in;
   logic [SAMPLE_PORT_BITS-1:0] blue_in;

   modport source (output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);

endinterface

/* sv/iorm_rsp_if.sv */
// ----------------------------------------------------------------------------
// iorm_rsp_if
// Result channel: one word per fetched pixel with its output coordinates.
// ----------------------------------------------------------------------------
interface iorm_rsp_if;
   import iorm_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [SAMPLE_PORT_BITS-1:0] red_out;
   logic [SAMPLE_PORT_BITS-1:0] green_out;
   logic [SAMPLE_PORT_BITS-1:0] blue_out;
   logic [COORD_PORT_BITS-1:0]  column_out;
   logic [COORD_PORT_BITS-1:0]  row_out;
   logic                        frame_last;

   modport source (output valid, red_out, green_out, blue_out, column_out, row_out,
                   frame_last, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, column_out, row_out,
                   frame_last, output ready);

endinterface

/* sv/iorm_csr_if.sv */
// ----------------------------------------------------------------------------
// iorm_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface iorm_csr_if;
   import iorm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] reg_index;
   logic [CSR_DATA_BITS-1:0]  reg_data;

   modport source (output valid, reg_index, reg_data, input ready);
   modport sink   (input valid, reg_index, reg_data, output ready);

endinterface

/* sv/image_orientation_remap_top.sv */
// ----------------------------------------------------------------------------
// image_orientation_remap_top: frame store that undoes an EXIF orientation.
// Throughput is one input word per cycle when not stalled, set by the single
// store port that serves either one pixel write or one pixel read each cycle.
// A fetch returns its result through stages A and B; a write word gives none.
// Reset (synchronous) clears the counters; the store is undefined until written.
// ----------------------------------------------------------------------------
module image_orientation_remap_top #(
   parameter int MAX_DIM     = iorm_pkg::MAX_DIM_DEFAULT,
   parameter int SAMPLE_BITS = iorm_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   iorm_req_if.sink   req_bus,
   iorm_rsp_if.source rsp_bus,
   iorm_csr_if.sink   csr_bus
);
   import iorm_pkg::*;

   // Dimension values run 1..MAX_DIM, coordinates 0..MAX_DIM-1.
   localparam int DIM_BITS   = $clog2(MAX_DIM + 1);
   localparam int COORD_BITS = $clog2(MAX_DIM);
   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int TOTAL_BITS = 2 * DIM_BITS;
   localparam int PROD_BITS  = COORD_BITS + DIM_BITS;
   localparam int PIX_BITS   = 3 * SAMPLE_BITS;

   // A register value of zero acts as one, anything above MAX_DIM as MAX_DIM.
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CFG_DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_BITS'(MAX_DIM);
      end else begin
         r = DIM_BITS'(v);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Configuration registers, always ready; the user must write only while
   // the block is idle, which the block does not enforce. A write raises
   // cfg_pend_ff for one cycle; it refreshes the derived geometry below and
   // holds off input. Reset raises it too so the geometry starts consistent.
   // ------------------------------------------------------------------------
   logic [CFG_DIM_BITS-1:0]  cfg_width_ff;
   logic [CFG_DIM_BITS-1:0]  cfg_height_ff;
   logic [CFG_CODE_BITS-1:0] cfg_code_ff;
   logic                     cfg_pend_ff;
   logic                     csr_fire;

   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= CFG_DIM_BITS'(1);
         cfg_height_ff <= CFG_DIM_BITS'(1);
         cfg_code_ff   <= ORIENT_TOP_LEFT;
         cfg_pend_ff   <= 1'b1;
      end else begin
         cfg_pend_ff <= csr_fire;
         if (csr_fire) begin
            unique case (csr_bus.reg_index)
               CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_bus.reg_data;
               CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_bus.reg_data;
               CSR_ORIENTATION:  cfg_code_ff   <= csr_bus.reg_data[CFG_CODE_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Derived geometry: clamped input size, output size (swapped for the
   // transposing codes), effective code and pixel count. These are registered
   // from the configuration registers, so they need no reset.
   // ------------------------------------------------------------------------
   logic [DIM_BITS-1:0]      dim_w_ff, dim_h_ff, out_w_ff, out_h_ff;
   logic [CFG_CODE_BITS-1:0] code_ff;
   logic [TOTAL_BITS-1:0]    total_ff;
   logic [DIM_BITS-1:0]      dim_w_in, dim_h_in;
   logic [CFG_CODE_BITS-1:0] code_in;
   logic                     transposed;

   always_comb begin
      dim_w_in = clamp_dim(cfg_width_ff);
      dim_h_in = clamp_dim(cfg_height_ff);
      // Codes outside the EXIF range behave as a plain pass-through.
      if (cfg_code_ff >= ORIENT_TOP_LEFT && cfg_code_ff <= ORIENT_LEFT_BOTTOM) begin
         code_in = cfg_code_ff;
      end else begin
         code_in = ORIENT_TOP_LEFT;
      end
      transposed = (code_in >= ORIENT_LEFT_TOP);
   end

   always_ff @(posedge clock) begin
      dim_w_ff <= dim_w_in;
      dim_h_ff <= dim_h_in;
      out_w_ff <= transposed ? dim_h_in : dim_w_in;
      out_h_ff <= transposed ? dim_w_in : dim_h_in;
      code_ff  <= code_in;
      total_ff <= TOTAL_BITS'(dim_w_in) * TOTAL_BITS'(dim_h_in);
   end

   // ------------------------------------------------------------------------
   // Pipeline control. Stage A holds the accepted word; stage B is the
   // result register fed by the synchronous store read. A write word in A
   // retires into the store unconditionally, a fetch word in A moves on
   // only when B is free. Because every store access happens from A in
   // acceptance order, a fetch always sees every earlier write and never a
   // later one, so no forwarding is needed.
   // ------------------------------------------------------------------------
   logic a_valid_ff, a_fetch_ff, b_valid_ff;
   logic b_en, a_go, a_en, req_fire, mem_we, mem_re;

   assign b_en          = !b_valid_ff || rsp_bus.ready;
   assign a_go          = a_valid_ff && (!a_fetch_ff || b_en);
   assign a_en          = !a_valid_ff || a_go;
   assign req_bus.ready = a_en && !cfg_pend_ff;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign mem_we        = a_valid_ff && !a_fetch_ff;
   assign mem_re        = a_valid_ff && a_fetch_ff && b_en;

   // ------------------------------------------------------------------------
   // Acceptance logic: the write pointer for write words, the output raster
   // walk and source coordinates for fetch words. Stale counters left over
   // from a geometry change restart at the origin.
   // ------------------------------------------------------------------------
   logic [ADDR_BITS-1:0]  wp_ff, wp_in, waddr;
   logic [TOTAL_BITS-1:0] waddr_inc;
   logic [COORD_BITS-1:0] col_ff, row_ff, col_in, row_in;
   logic [DIM_BITS-1:0]   xe, ye, w_m1, h_m1, sx, sy;
   logic                  fetch_last;

   always_comb begin
      // Write pointer.
      waddr     = (TOTAL_BITS'(wp_ff) >= total_ff) ? '0 : wp_ff;
      waddr_inc = TOTAL_BITS'(waddr) + TOTAL_BITS'(1);
      wp_in     = (waddr_inc >= total_ff) ? '0 : ADDR_BITS'(waddr_inc);

      // Output position, restarted when outside the current output frame.
      xe = DIM_BITS'(col_ff);
      ye = DIM_BITS'(row_ff);
      if (xe >= out_w_ff || ye >= out_h_ff) begin
         xe = '0;
         ye = '0;
      end
      w_m1 = dim_w_ff - DIM_BITS'(1);
      h_m1 = dim_h_ff - DIM_BITS'(1);

      case (code_ff) inside
         ORIENT_TOP_RIGHT, ORIENT_BOTTOM_RIGHT:   sx = w_m1 - xe;
         ORIENT_LEFT_TOP, ORIENT_RIGHT_TOP:       sx = ye;
         ORIENT_RIGHT_BOTTOM, ORIENT_LEFT_BOTTOM: sx = w_m1 - ye;
         default:                                 sx = xe;
      endcase
      case (code_ff) inside
         ORIENT_BOTTOM_RIGHT, ORIENT_BOTTOM_LEFT: sy = h_m1 - ye;
         ORIENT_LEFT_TOP, ORIENT_LEFT_BOTTOM:     sy = xe;
         ORIENT_RIGHT_TOP, ORIENT_RIGHT_BOTTOM:   sy = h_m1 - xe;
         default:                                 sy = ye;
      endcase

      fetch_last = (xe == out_w_ff - DIM_BITS'(1)) && (ye == out_h_ff - DIM_BITS'(1));

      // Advance along the output raster, wrapping after the last pixel.
      if (xe + DIM_BITS'(1) < out_w_ff) begin
         col_in = COORD_BITS'(xe + DIM_BITS'(1));
         row_in = COORD_BITS'(ye);
      end else if (ye + DIM_BITS'(1) < out_h_ff) begin
         col_in = '0;
         row_in = COORD_BITS'(ye + DIM_BITS'(1));
      end else begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         if (req_bus.kind == KIND_WRITE) begin
            wp_ff <= wp_in;
         end else begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage A registers.
   // ------------------------------------------------------------------------
   logic [ADDR_BITS-1:0]  a_waddr_ff;
   logic [PIX_BITS-1:0]   a_pixel_ff;
   logic [COORD_BITS-1:0] a_sx_ff, a_sy_ff, a_col_ff, a_row_ff;
   logic                  a_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_fetch_ff <= (req_bus.kind == KIND_FETCH);
         a_waddr_ff <= waddr;
         a_pixel_ff <= {SAMPLE_BITS'(req_bus.red_in), SAMPLE_BITS'(req_bus.green_in),
                        SAMPLE_BITS'(req_bus.blue_in)};
         a_sx_ff    <= COORD_BITS'(sx);
         a_sy_ff    <= COORD_BITS'(sy);
         a_col_ff   <= COORD_BITS'(xe);
         a_row_ff   <= COORD_BITS'(ye);
         a_last_ff  <= fetch_last;
      end
   end

   // Source address of a fetch: one multiply and add, row-major.
   logic [PROD_BITS-1:0] rd_prod;
   logic [ADDR_BITS-1:0] rd_addr;

   assign rd_prod = PROD_BITS'(a_sy_ff) * PROD_BITS'(dim_w_ff);
   assign rd_addr = ADDR_BITS'(rd_prod + PROD_BITS'(a_sx_ff));

   // ------------------------------------------------------------------------
   // Frame store: single port, registered read. Reads and writes never share
   // a cycle since stage A holds only one word.
   // ------------------------------------------------------------------------
   logic [PIX_BITS-1:0] frame_store [DEPTH];
   logic [PIX_BITS-1:0] b_pixel_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store[a_waddr_ff] <= a_pixel_ff;
      end
      if (mem_re) begin
         b_pixel_ff <= frame_store[rd_addr];
      end
   end

   // ------------------------------------------------------------------------
   // Stage B: result register that drives the response channel.
   // ------------------------------------------------------------------------
   logic [COORD_BITS-1:0] b_col_ff, b_row_ff;
   logic                  b_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= mem_re;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         b_col_ff  <= a_col_ff;
         b_row_ff  <= a_row_ff;
         b_last_ff <= a_last_ff;
      end
   end

   assign rsp_bus.valid      = b_valid_ff;
   assign rsp_bus.red_out    = SAMPLE_PORT_BITS'(b_pixel_ff[2*SAMPLE_BITS +: SAMPLE_BITS]);
   assign rsp_bus.green_out  = SAMPLE_PORT_BITS'(b_pixel_ff[SAMPLE_BITS +: SAMPLE_BITS]);
   assign rsp_bus.blue_out   = SAMPLE_PORT_BITS'(b_pixel_ff[0 +: SAMPLE_BITS]);
   assign rsp_bus.column_out = COORD_PORT_BITS'(b_col_ff);
   assign rsp_bus.row_out    = COORD_PORT_BITS'(b_row_ff);
   assign rsp_bus.frame_last = b_last_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // The single store port never sees a read and a write in the same cycle.
   assert property (@(posedge clock) disable iff (reset) mem_we |-> !mem_re)
      else $error("frame store read and write collide");

   // The cycle after a configuration write the geometry is refreshing, so no
   // input word may be taken.
   assert property (@(posedge clock) disable iff (reset) csr_fire |=> !req_bus.ready)
      else $error("input accepted during geometry refresh");

   // After a write word the pointer lies inside the frame.
   assert property (@(posedge clock) disable iff (reset)
                    (req_fire && req_bus.kind == KIND_WRITE)
                    |=> (TOTAL_BITS'(wp_ff) < total_ff))
      else $error("write pointer outside frame");

endmodule
